// File: rtl/clr_pkg.sv
// Shared types, widths and codes of the correlation and linear regression block.
package clr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CNT_W      = 13;
  localparam int MAX_POINTS = 4096;
  localparam int SUM_W      = 29;
  localparam int SQ_W       = 44;
  localparam int WIDE_W     = 144;
  localparam int MPL_W      = 60;
  localparam int QUO_W      = 40;
  localparam int DIVCNT_W   = 8;
  localparam int SQRT_W     = 32;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_X_CONST  = 2'd1;
  localparam logic [1:0] STATUS_Y_CONST  = 2'd2;
  localparam logic [1:0] STATUS_CAPACITY = 2'd3;

  localparam logic [4:0] SH_NONE  = 5'd0;
  localparam logic [4:0] SH_ICPT  = 5'd8;
  localparam logic [4:0] SH_SLOPE = 5'd16;
  localparam logic [4:0] SH_CORR  = 5'd28;

  typedef enum logic [3:0] {
    SEL_N, SEL_SX, SEL_SY, SEL_SXX, SEL_SYY, SEL_SXY,
    SEL_DXX, SEL_DYY, SEL_DXY, SEL_T, SEL_U
  } sel_e;

  typedef enum logic [2:0] {
    OP_CLR, OP_MUL, OP_SUB, OP_DIVR, OP_DIVQ, OP_SQRT
  } op_e;

  typedef enum logic [2:0] {
    DST_T, DST_U, DST_DXX, DST_DYY, DST_DXY, DST_SLOPE, DST_ICPT, DST_CORR
  } dst_e;

  typedef struct packed {
    logic       go;
    op_e        op;
    sel_e       a_sel;
    sel_e       b_sel;
    dst_e       dst;
    logic [4:0] shamt;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic dxx_zero;
    logic dyy_zero;
  } dp_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic [SQ_W-1:0]         sxx;
    logic [SQ_W-1:0]         syy;
    logic signed [SQ_W-1:0]  sxy;
    logic                    overflow;
  } sums_t;

endpackage

// File: rtl/clr_accum.sv
// Running sums of one set of points, taking one point per clock cycle while accept_i is high.
module clr_accum (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic signed [clr_pkg::SAMPLE_W-1:0]  x_value_i,
  input  logic signed [clr_pkg::SAMPLE_W-1:0]  y_value_i,
  input  logic                                 clear_i,
  output clr_pkg::sums_t                       sums_o
);
  import clr_pkg::*;

  logic                       full;
  logic                       take;
  logic                       vld_q;
  logic signed [SAMPLE_W-1:0] x_q, y_q;
  logic signed [2*SAMPLE_W-1:0] xx_q, yy_q, xy_q;
  logic signed [2*SAMPLE_W-1:0] xx_d, yy_d, xy_d;
  logic [CNT_W-1:0]           count_q;
  logic                       overflow_q;
  logic signed [SUM_W-1:0]    sx_q, sy_q;
  logic [SQ_W-1:0]            sxx_q, syy_q;
  logic signed [SQ_W-1:0]     sxy_q;

  assign full = (count_q == CNT_W'(MAX_POINTS));
  assign take = accept_i && !full;
  assign xx_d = x_value_i * x_value_i;
  assign yy_d = y_value_i * y_value_i;
  assign xy_d = x_value_i * y_value_i;

  // Products are registered first; the sums take them in the cycle after.
  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q  <= x_value_i;
      y_q  <= y_value_i;
      xx_q <= xx_d;
      yy_q <= yy_d;
      xy_q <= xy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= 1'b0;
      count_q    <= '0;
      overflow_q <= 1'b0;
      sx_q       <= '0;
      sy_q       <= '0;
      sxx_q      <= '0;
      syy_q      <= '0;
      sxy_q      <= '0;
    end else if (clear_i) begin
      vld_q      <= 1'b0;
      count_q    <= '0;
      overflow_q <= 1'b0;
      sx_q       <= '0;
      sy_q       <= '0;
      sxx_q      <= '0;
      syy_q      <= '0;
      sxy_q      <= '0;
    end else begin
      vld_q <= take;
      if (take) begin
        count_q <= count_q + 1'b1;
      end
      if (accept_i && full) begin
        overflow_q <= 1'b1;
      end
      if (vld_q) begin
        sx_q  <= sx_q + {{(SUM_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
        sy_q  <= sy_q + {{(SUM_W-SAMPLE_W){y_q[SAMPLE_W-1]}}, y_q};
        sxx_q <= sxx_q + {{(SQ_W-2*SAMPLE_W){1'b0}}, xx_q};
        syy_q <= syy_q + {{(SQ_W-2*SAMPLE_W){1'b0}}, yy_q};
        sxy_q <= sxy_q + {{(SQ_W-2*SAMPLE_W){xy_q[2*SAMPLE_W-1]}}, xy_q};
      end
    end
  end

  assign sums_o.count    = count_q;
  assign sums_o.sx       = sx_q;
  assign sums_o.sy       = sy_q;
  assign sums_o.sxx      = sxx_q;
  assign sums_o.syy      = syy_q;
  assign sums_o.sxy      = sxy_q;
  assign sums_o.overflow = overflow_q;

endmodule

// File: rtl/clr_dp.sv
// Final datapath: serial multiplier, restoring divider and square root over wide registers.
module clr_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  clr_pkg::dp_cmd_t                      cmd_i,
  input  clr_pkg::sums_t                        sums_i,
  output clr_pkg::dp_stat_t                     stat_o,
  output logic signed [15:0]                    correlation_o,
  output logic signed [31:0]                    slope_o,
  output logic signed [31:0]                    intercept_o
);
  import clr_pkg::*;

  logic                  run_q, done_q;
  op_e                   op_q;
  dst_e                  dst_q;
  logic [WIDE_W-1:0]     t_q, u_q, dxx_q, dyy_q, dxy_q;
  logic [WIDE_W-1:0]     mc_q, acc_q;
  logic [MPL_W-1:0]      mp_q;
  logic                  neg_q;
  logic [WIDE_W-1:0]     num_q, rem_q, den_q;
  logic [QUO_W-1:0]      quo_q;
  logic                  sticky_q;
  logic [DIVCNT_W-1:0]   cnt_q;
  logic [SQRT_W-1:0]     sv_q, sr_q, sb_q;
  logic                  big_q;
  logic signed [15:0]    corr_q;
  logic signed [31:0]    slope_q, icpt_q;

  logic [WIDE_W-1:0]     a_val, b_val, a_mag, b_mag;
  logic                  a_neg, b_neg;
  logic [WIDE_W-1:0]     acc_sum, rem_sh, rem_sub;
  logic                  rem_ge;
  logic [QUO_W-1:0]      limit, sat_mag;
  logic [31:0]           sat_val;
  logic [SQRT_W-1:0]     trial, sq_mag;
  logic                  sq_ge;
  logic [15:0]           corr_val;
  logic                  fin;
  logic                  wr_en;
  dst_e                  wr_dst;
  logic [WIDE_W-1:0]     wr_val;

  function automatic logic [WIDE_W-1:0] opnd(sel_e s);
    logic [WIDE_W-1:0] v;
    case (s)
      SEL_N:   v = {{(WIDE_W-CNT_W){1'b0}}, sums_i.count};
      SEL_SX:  v = {{(WIDE_W-SUM_W){sums_i.sx[SUM_W-1]}}, sums_i.sx};
      SEL_SY:  v = {{(WIDE_W-SUM_W){sums_i.sy[SUM_W-1]}}, sums_i.sy};
      SEL_SXX: v = {{(WIDE_W-SQ_W){1'b0}}, sums_i.sxx};
      SEL_SYY: v = {{(WIDE_W-SQ_W){1'b0}}, sums_i.syy};
      SEL_SXY: v = {{(WIDE_W-SQ_W){sums_i.sxy[SQ_W-1]}}, sums_i.sxy};
      SEL_DXX: v = dxx_q;
      SEL_DYY: v = dyy_q;
      SEL_DXY: v = dxy_q;
      SEL_T:   v = t_q;
      SEL_U:   v = u_q;
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    a_val = opnd(cmd_i.a_sel);
    b_val = opnd(cmd_i.b_sel);
    a_neg = a_val[WIDE_W-1];
    b_neg = b_val[WIDE_W-1];
    a_mag = a_neg ? -a_val : a_val;
    b_mag = b_neg ? -b_val : b_val;

    acc_sum = acc_q + (mp_q[0] ? mc_q : '0);
    rem_sh  = {rem_q[WIDE_W-2:0], num_q[WIDE_W-1]};
    rem_ge  = (rem_sh >= den_q);
    rem_sub = rem_sh - den_q;

    // Rounded quotient saturated to the signed 32-bit range.
    limit   = neg_q ? (QUO_W'(1) << 31) : ((QUO_W'(1) << 31) - QUO_W'(1));
    sat_mag = (sticky_q || (quo_q > limit)) ? limit : quo_q;
    sat_val = neg_q ? -sat_mag[31:0] : sat_mag[31:0];

    trial    = sr_q + sb_q;
    sq_ge    = (sv_q >= trial);
    sq_mag   = (big_q || (sr_q > SQRT_W'(16384))) ? SQRT_W'(16384) : sr_q;
    corr_val = neg_q ? -sq_mag[15:0] : sq_mag[15:0];

    fin = 1'b0;
    if (run_q) begin
      case (op_q)
        OP_MUL:           fin = (mp_q == '0);
        OP_DIVR, OP_DIVQ: fin = (cnt_q == '0);
        OP_SQRT:          fin = (sb_q == '0);
        default:          fin = 1'b1;
      endcase
    end

    wr_en  = 1'b0;
    wr_dst = dst_q;
    wr_val = '0;
    if (cmd_i.go && (cmd_i.op == OP_SUB)) begin
      wr_en  = 1'b1;
      wr_dst = cmd_i.dst;
      wr_val = a_val - b_val;
    end else if (fin) begin
      case (op_q)
        OP_MUL: begin
          wr_en  = 1'b1;
          wr_val = neg_q ? -acc_q : acc_q;
        end
        OP_DIVR: begin
          wr_en  = 1'b1;
          wr_val = {{(WIDE_W-32){sat_val[31]}}, sat_val};
        end
        OP_SQRT: begin
          wr_en  = 1'b1;
          wr_val = {{(WIDE_W-16){corr_val[15]}}, corr_val};
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.go) begin
        run_q  <= (cmd_i.op != OP_CLR) && (cmd_i.op != OP_SUB);
        done_q <= (cmd_i.op == OP_SUB);
      end else if (fin) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.go) begin
      op_q  <= cmd_i.op;
      dst_q <= cmd_i.dst;
      case (cmd_i.op)
        OP_CLR: begin
          slope_q <= '0;
          corr_q  <= '0;
        end
        OP_MUL: begin
          mc_q  <= a_mag;
          mp_q  <= b_mag[MPL_W-1:0];
          acc_q <= '0;
          neg_q <= a_neg ^ b_neg;
        end
        OP_DIVR: begin
          // round(a * 2^s / b) is floor((a * 2^(s+1) + b) / 2b).
          num_q    <= (a_mag << (6'(cmd_i.shamt) + 6'd1)) + b_mag;
          den_q    <= b_mag << 1;
          rem_q    <= '0;
          quo_q    <= '0;
          sticky_q <= 1'b0;
          cnt_q    <= DIVCNT_W'(WIDE_W);
          neg_q    <= a_neg;
        end
        OP_DIVQ: begin
          num_q    <= a_mag << cmd_i.shamt;
          den_q    <= b_mag;
          rem_q    <= '0;
          quo_q    <= '0;
          sticky_q <= 1'b0;
          cnt_q    <= DIVCNT_W'(WIDE_W);
          neg_q    <= 1'b0;
        end
        OP_SQRT: begin
          sr_q  <= '0;
          sb_q  <= SQRT_W'(1) << (SQRT_W - 2);
          neg_q <= dxy_q[WIDE_W-1];
        end
        default: ;
      endcase
    end else if (run_q && !fin) begin
      case (op_q)
        OP_MUL: begin
          acc_q <= acc_sum;
          mc_q  <= mc_q << 1;
          mp_q  <= mp_q >> 1;
        end
        OP_DIVR, OP_DIVQ: begin
          rem_q    <= rem_ge ? rem_sub : rem_sh;
          quo_q    <= {quo_q[QUO_W-2:0], rem_ge};
          sticky_q <= sticky_q | quo_q[QUO_W-1];
          num_q    <= num_q << 1;
          cnt_q    <= cnt_q - 1'b1;
        end
        OP_SQRT: begin
          if (sq_ge) begin
            sv_q <= sv_q - trial;
            sr_q <= (sr_q >> 1) + sb_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sb_q <= sb_q >> 2;
        end
        default: ;
      endcase
    end else if (fin && (op_q == OP_DIVQ)) begin
      sv_q  <= quo_q[SQRT_W-1:0];
      big_q <= sticky_q | (|quo_q[QUO_W-1:SQRT_W]);
    end

    if (wr_en) begin
      case (wr_dst)
        DST_T:     t_q     <= wr_val;
        DST_U:     u_q     <= wr_val;
        DST_DXX:   dxx_q   <= wr_val;
        DST_DYY:   dyy_q   <= wr_val;
        DST_DXY:   dxy_q   <= wr_val;
        DST_SLOPE: slope_q <= wr_val[31:0];
        DST_ICPT:  icpt_q  <= wr_val[31:0];
        DST_CORR:  corr_q  <= wr_val[15:0];
        default:   ;
      endcase
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.dxx_zero = (dxx_q == '0);
  assign stat_o.dyy_zero = (dyy_q == '0);
  assign correlation_o   = corr_q;
  assign slope_o         = slope_q;
  assign intercept_o     = icpt_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q)
    else $error("datapath done while still running");
  a_sub_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.go && (cmd_i.op == OP_SUB)) |=> done_q)
    else $error("subtraction did not complete in one cycle");
  a_no_go_when_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> !cmd_i.go)
    else $error("command issued while datapath busy");

endmodule

// File: rtl/clr_ctrl.sv
// Sequencer that steps the datapath through the end-of-set computation.
module clr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               last_point_i,
  input  clr_pkg::dp_stat_t  stat_i,
  output clr_pkg::dp_cmd_t   cmd_o,
  output logic               busy_o,
  output logic               result_valid_o,
  output logic               clear_o
);
  import clr_pkg::*;

  localparam logic [2:0] ST_ACC   = 3'd0;
  localparam logic [2:0] ST_FLUSH = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [4:0] PC_FIRST     = 5'd0;
  localparam logic [4:0] PC_DXY       = 5'd8;
  localparam logic [4:0] PC_ICPT_MEAN = 5'd9;
  localparam logic [4:0] PC_SLOPE     = 5'd10;
  localparam logic [4:0] PC_ICPT      = 5'd15;
  localparam logic [4:0] PC_SQRT      = 5'd19;

  logic [2:0] state_q, state_d;
  logic [4:0] pc_q, pc_d;

  function automatic dp_cmd_t mk(op_e op, sel_e a, sel_e b, dst_e d, logic [4:0] sh);
    dp_cmd_t c;
    c.go    = 1'b1;
    c.op    = op;
    c.a_sel = a;
    c.b_sel = b;
    c.dst   = d;
    c.shamt = sh;
    return c;
  endfunction

  // Program: three centred sums, slope, intercept, correlation; constant x: mean y only, constant y: no correlation.
  function automatic dp_cmd_t uop(logic [4:0] pc);
    dp_cmd_t c;
    case (pc)
      5'd0:    c = mk(OP_MUL,  SEL_SXX, SEL_N,   DST_T,     SH_NONE);
      5'd1:    c = mk(OP_MUL,  SEL_SX,  SEL_SX,  DST_U,     SH_NONE);
      5'd2:    c = mk(OP_SUB,  SEL_T,   SEL_U,   DST_DXX,   SH_NONE);
      5'd3:    c = mk(OP_MUL,  SEL_SYY, SEL_N,   DST_T,     SH_NONE);
      5'd4:    c = mk(OP_MUL,  SEL_SY,  SEL_SY,  DST_U,     SH_NONE);
      5'd5:    c = mk(OP_SUB,  SEL_T,   SEL_U,   DST_DYY,   SH_NONE);
      5'd6:    c = mk(OP_MUL,  SEL_SXY, SEL_N,   DST_T,     SH_NONE);
      5'd7:    c = mk(OP_MUL,  SEL_SX,  SEL_SY,  DST_U,     SH_NONE);
      5'd8:    c = mk(OP_SUB,  SEL_T,   SEL_U,   DST_DXY,   SH_NONE);
      5'd9:    c = mk(OP_DIVR, SEL_SY,  SEL_N,   DST_ICPT,  SH_ICPT);
      5'd10:   c = mk(OP_DIVR, SEL_DXY, SEL_DXX, DST_SLOPE, SH_SLOPE);
      5'd11:   c = mk(OP_MUL,  SEL_SY,  SEL_DXX, DST_T,     SH_NONE);
      5'd12:   c = mk(OP_MUL,  SEL_DXY, SEL_SX,  DST_U,     SH_NONE);
      5'd13:   c = mk(OP_SUB,  SEL_T,   SEL_U,   DST_T,     SH_NONE);
      5'd14:   c = mk(OP_MUL,  SEL_DXX, SEL_N,   DST_U,     SH_NONE);
      5'd15:   c = mk(OP_DIVR, SEL_T,   SEL_U,   DST_ICPT,  SH_ICPT);
      5'd16:   c = mk(OP_MUL,  SEL_DXY, SEL_DXY, DST_T,     SH_NONE);
      5'd17:   c = mk(OP_MUL,  SEL_DXX, SEL_DYY, DST_U,     SH_NONE);
      5'd18:   c = mk(OP_DIVQ, SEL_T,   SEL_U,   DST_T,     SH_CORR);
      5'd19:   c = mk(OP_SQRT, SEL_T,   SEL_U,   DST_CORR,  SH_NONE);
      default: c = mk(OP_CLR,  SEL_N,   SEL_N,   DST_T,     SH_NONE);
    endcase
    return c;
  endfunction

  always_comb begin
    state_d        = state_q;
    pc_d           = pc_q;
    cmd_o          = mk(OP_CLR, SEL_N, SEL_N, DST_T, SH_NONE);
    cmd_o.go       = 1'b0;
    result_valid_o = 1'b0;
    clear_o        = 1'b0;
    case (state_q)
      ST_ACC: begin
        if (accept_i && last_point_i) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // The last product lands in the sums here; slope and correlation fields are zeroed.
        cmd_o   = mk(OP_CLR, SEL_N, SEL_N, DST_T, SH_NONE);
        pc_d    = PC_FIRST;
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd_o   = uop(pc_q);
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat_i.done) begin
          state_d = ST_ISSUE;
          pc_d    = pc_q + 1'b1;
          if (pc_q == PC_DXY) begin
            pc_d = stat_i.dxx_zero ? PC_ICPT_MEAN : PC_SLOPE;
          end else if ((pc_q == PC_ICPT_MEAN) || (pc_q == PC_SQRT)) begin
            state_d = ST_OUT;
          end else if ((pc_q == PC_ICPT) && stat_i.dyy_zero) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        result_valid_o = 1'b1;
        clear_o        = 1'b1;
        state_d        = ST_ACC;
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      pc_q    <= PC_FIRST;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  assign busy_o = (state_q != ST_ACC);

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_point_i) |=> (state_q == ST_FLUSH))
    else $error("last point did not start the final computation");
  a_out_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |=> (state_q == ST_ACC))
    else $error("controller did not return after the result");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> (state_q == ST_ACC))
    else $error("point accepted while busy");

endmodule

// File: rtl/correlation_and_linear_regression.sv
// Top level of the correlation and least-squares line block.
// Points of a set arrive one per beat, one beat per clock cycle, for as long as busy is low;
// an item is taken at a rising edge with start high and busy low. The set's last point, marked
// by last_point_i, raises busy and starts the final computation, which runs through one
// serial multiplier (one multiplier bit a cycle), one restoring divider and a square root of
// sixteen steps, all shared and driven by a sequencer. The time depends on the data, mainly
// on the bit length of each multiplication's second operand. The result is then shown for
// exactly one cycle with result_valid_o high; the receiver cannot hold it off and must take
// it in that cycle. The sums clear in the same cycle and busy falls in the next one, so the
// next set may begin at once. Points beyond the capacity of 4096 per set are ignored and
// reported through status_o.
module correlation_and_linear_regression (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] x_value_i,
  input  logic signed [15:0] y_value_i,
  input  logic               last_point_i,
  output logic               result_valid_o,
  output logic signed [15:0] correlation_o,
  output logic signed [31:0] slope_o,
  output logic signed [31:0] intercept_o,
  output logic [1:0]         status_o,
  output logic [12:0]        points_used_o
);
  import clr_pkg::*;

  logic     accept;
  logic     clear;
  sums_t    sums;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign accept = start && !busy;

  clr_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .x_value_i (x_value_i),
    .y_value_i (y_value_i),
    .clear_i   (clear),
    .sums_o    (sums)
  );

  clr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .last_point_i   (last_point_i),
    .stat_i         (dp_stat),
    .cmd_o          (dp_cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .clear_o        (clear)
  );

  clr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sums_i        (sums),
    .stat_o        (dp_stat),
    .correlation_o (correlation_o),
    .slope_o       (slope_o),
    .intercept_o   (intercept_o)
  );

  // A set that overran capacity is reported first, then a constant x, then a constant y.
  always_comb begin
    if (sums.overflow) begin
      status_o = STATUS_CAPACITY;
    end else if (dp_stat.dxx_zero) begin
      status_o = STATUS_X_CONST;
    end else if (dp_stat.dyy_zero) begin
      status_o = STATUS_Y_CONST;
    end else begin
      status_o = STATUS_OK;
    end
  end

  assign points_used_o = sums.count;

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result shown while idle");
  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_point_i) |=> busy)
    else $error("busy did not rise after the last point");
  a_corr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((correlation_o <= 16'sd16384) && (correlation_o >= -16'sd16384)))
    else $error("correlation out of range");

endmodule
